// ----- hdl/sh4x_pkg.sv -----
`default_nettype none

package sh4x_pkg;

    localparam int REG_COUNT   = 16;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);

    localparam logic [31:0] PC_RESET = 32'hA000_0000;
    localparam logic [31:0] PC_STEP  = 32'd2;

    // opcode fields
    localparam logic [3:0] OP_MOVI  = 4'hE;
    localparam logic [3:0] OP_SHIFT = 4'h4;
    localparam logic [3:0] OP_SWAP  = 4'h6;
    localparam logic [3:0] FN_SWAP  = 4'h9;
    localparam logic [3:0] OP_MOVL  = 4'h5;
    localparam logic [7:0] OP_MOVB  = 8'h84;
    localparam logic [7:0] OP_MOVW  = 8'h85;

    localparam logic [7:0] SH_LL1  = 8'h00;
    localparam logic [7:0] SH_LR1  = 8'h01;
    localparam logic [7:0] SH_LL2  = 8'h08;
    localparam logic [7:0] SH_LR2  = 8'h09;
    localparam logic [7:0] SH_LL8  = 8'h18;
    localparam logic [7:0] SH_LR8  = 8'h19;
    localparam logic [7:0] SH_LL16 = 8'h28;
    localparam logic [7:0] SH_LR16 = 8'h29;

    // top three address bits of the mapped regions
    localparam logic [2:0] AREA_P2 = 3'b101;
    localparam logic [2:0] AREA_P4 = 3'b111;

    typedef enum logic {
        ACT_EXEC   = 1'b0,
        ACT_RETURN = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_REQUEST  = 3'd1,
        ST_LOADED   = 3'd2,
        ST_UNDEF    = 3'd3,
        ST_UNMAPPED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_WORD = 2'd1,
        SZ_LONG = 2'd2
    } t_size;

    typedef struct packed {
        logic                 t;
        logic [31:0]          pc;
        logic                 pend;
        logic [REG_IDX_W-1:0] pdest;
        t_size                psize;
    } t_arch;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [31:0]          data;
    } t_rf_wr;

    typedef struct packed {
        t_status              status;
        logic [31:0]          pc;
        logic [28:0]          addr;
        t_size                size;
        logic                 region;
        logic [REG_IDX_W-1:0] dreg;
        logic [31:0]          dval;
        logic                 t;
        logic [1:0]           cyc;
    } t_result;

    function automatic logic [31:0] sext_size(input logic [31:0] v, input t_size sz);
        logic [31:0] r;
        case (sz)
            SZ_BYTE: r = {{24{v[7]}}, v[7:0]};
            SZ_WORD: r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sh4_subset_execute_unit.sv -----
`default_nettype none

// channel   dir  handshake             payload
// s         in   i_s_tvalid/o_s_tready tdata 48b, tuser 1b (action)
// m         out  o_m_tvalid/i_m_tready tdata 104b, tuser 3b (status)
//
// result path: the transfer edge captures the item and its register reads, and a
// later edge, once the output register is empty or taken, executes it into the output register
// one item per cycle sustained; input stalls only while the output register is full
// and not taken
// reset: pc 0xa0000000, t clear, no load pending, all registers read as zero
// register writes are bypassed to the read stage so back-to-back items see them

module sh4_subset_execute_unit
    import sh4x_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // [15:0] instr_word, [47:16] load_data
    input  wire logic [47:0]  i_s_tdata,
    // [0] action
    input  wire logic [0:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [31:0] instr_pc, [60:32] mem_address, [62:61] mem_size, [63] mem_region,
    // [67:64] dest_reg, [99:68] dest_value, [100] t_flag, [102:101] instr_cycles,
    // [103] zero
    output logic [103:0]      o_m_tdata,
    // [2:0] status
    output logic [2:0]        o_m_tuser
);

    logic        r_s1_v;
    t_action     r_s1_act;
    logic [15:0] r_s1_instr;
    logic [31:0] r_s1_data;
    logic        r_out_v;
    t_result     r_out;
    t_arch       r_arch;

    t_arch       n_arch;
    t_result     n_out;
    t_rf_wr      rf_wr;
    t_rf_wr      alu_wr;
    logic [31:0] rd_n;
    logic [31:0] rd_m;
    logic        adv;
    logic        s_xfer;

    assign adv        = r_s1_v && (!r_out_v || i_m_tready);
    assign o_s_tready = !r_s1_v || adv;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    sh4x_regfile u_rf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (s_xfer),
        .i_rd_addr_a (i_s_tdata[11:8]),
        .i_rd_addr_b (i_s_tdata[7:4]),
        .o_rd_data_a (rd_n),
        .o_rd_data_b (rd_m),
        .i_wr        (rf_wr)
    );

    sh4x_alu u_alu (
        .i_action    (r_s1_act),
        .i_instr     (r_s1_instr),
        .i_load_data (r_s1_data),
        .i_rd_n      (rd_n),
        .i_rd_m      (rd_m),
        .i_state     (r_arch),
        .o_state     (n_arch),
        .o_wr        (alu_wr),
        .o_res       (n_out)
    );

    always_comb begin
        rf_wr    = alu_wr;
        rf_wr.en = alu_wr.en && adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_act   <= t_action'(i_s_tuser[0]);
            r_s1_instr <= i_s_tdata[15:0];
            r_s1_data  <= i_s_tdata[47:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch.t     <= 1'b0;
            r_arch.pc    <= PC_RESET;
            r_arch.pend  <= 1'b0;
            r_arch.pdest <= '0;
            r_arch.psize <= SZ_BYTE;
        end else if (adv) begin
            r_arch <= n_arch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {1'b0, r_out.cyc, r_out.t, r_out.dval, r_out.dreg,
                         r_out.region, r_out.size, r_out.addr, r_out.pc};

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_arch.pc == PC_RESET) && !r_arch.pend && !r_out_v)
        else $error("state not cleared by reset");

    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_s1_act == ACT_EXEC |=> r_arch.pc == $past(r_arch.pc) + PC_STEP)
        else $error("pc did not advance on execute");

    a_return_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_s1_act == ACT_RETURN |=> !r_arch.pend)
        else $error("load still pending after return");

    a_adv_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_m_tvalid)
        else $error("executed item not presented");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

// ----- hdl/sh4x_regfile.sv -----
`default_nettype none

module sh4x_regfile
    import sh4x_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [REG_IDX_W-1:0] i_rd_addr_a,
    input  wire logic [REG_IDX_W-1:0] i_rd_addr_b,
    output logic [31:0]               o_rd_data_a,
    output logic [31:0]               o_rd_data_b,
    input  wire t_rf_wr               i_wr
);

    logic [31:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [31:0]          r_rd_a;
    logic [31:0]          r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // read with bypass of the write landing at the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && i_wr.addr == i_rd_addr_a) begin
                r_rd_a <= i_wr.data;
            end else begin
                r_rd_a <= r_valid[i_rd_addr_a] ? r_mem[i_rd_addr_a] : 32'd0;
            end
            if (i_wr.en && i_wr.addr == i_rd_addr_b) begin
                r_rd_b <= i_wr.data;
            end else begin
                r_rd_b <= r_valid[i_rd_addr_b] ? r_mem[i_rd_addr_b] : 32'd0;
            end
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

// ----- hdl/sh4x_alu.sv -----
`default_nettype none

module sh4x_alu
    import sh4x_pkg::*;
(
    input  wire t_action     i_action,
    input  wire logic [15:0] i_instr,
    input  wire logic [31:0] i_load_data,
    input  wire logic [31:0] i_rd_n,
    input  wire logic [31:0] i_rd_m,
    input  wire t_arch       i_state,
    output t_arch            o_state,
    output t_rf_wr           o_wr,
    output t_result          o_res
);

    always_comb begin
        logic [3:0]  n;
        logic [3:0]  m;
        logic [3:0]  d;
        logic [7:0]  lo;
        logic [4:0]  amt;
        logic [31:0] shv;
        logic [31:0] addr;
        logic        is_load;
        logic        is_shift;
        logic        p2;
        logic        p4;

        n        = i_instr[11:8];
        m        = i_instr[7:4];
        d        = i_instr[3:0];
        lo       = i_instr[7:0];
        addr     = 32'd0;
        is_load  = 1'b0;
        p2       = 1'b0;
        p4       = 1'b0;
        is_shift = (lo == SH_LL1) || (lo == SH_LR1) || (lo == SH_LL2) || (lo == SH_LR2)
                || (lo == SH_LL8) || (lo == SH_LR8) || (lo == SH_LL16) || (lo == SH_LR16);

        case (lo[5:4])
            2'd0:    amt = lo[3] ? 5'd2 : 5'd1;
            2'd1:    amt = 5'd8;
            default: amt = 5'd16;
        endcase
        shv = lo[0] ? (i_rd_n >> amt) : (i_rd_n << amt);

        o_state        = i_state;
        o_wr           = '0;
        o_res          = '0;
        o_res.status   = ST_DONE;
        o_res.size     = SZ_BYTE;

        if (i_action == ACT_RETURN) begin
            o_res.pc = i_state.pc - PC_STEP;
            if (i_state.pend) begin
                o_res.status = ST_LOADED;
                o_res.dreg   = i_state.pdest;
                o_res.dval   = sext_size(i_load_data, i_state.psize);
                o_res.size   = i_state.psize;
                o_state.pend = 1'b0;
                o_wr.en      = 1'b1;
            end
        end else begin
            o_res.pc   = i_state.pc;
            o_state.pc = i_state.pc + PC_STEP;

            if (i_instr[15:12] == OP_MOVI) begin
                o_res.dreg = n;
                o_res.dval = {{24{lo[7]}}, lo};
                o_res.cyc  = 2'd1;
                o_wr.en    = 1'b1;
            end else if (i_instr[15:12] == OP_SHIFT && is_shift) begin
                // only the one-bit forms touch T
                if (amt == 5'd1) begin
                    o_state.t = lo[0] ? i_rd_n[0] : i_rd_n[31];
                end
                o_res.dreg = n;
                o_res.dval = shv;
                o_res.cyc  = 2'd1;
                o_wr.en    = 1'b1;
            end else if (i_instr[15:12] == OP_SWAP && d == FN_SWAP) begin
                o_res.dreg = n;
                o_res.dval = {i_rd_m[15:0], i_rd_m[31:16]};
                o_res.cyc  = 2'd1;
                o_wr.en    = 1'b1;
            end else if (i_instr[15:12] == OP_MOVL) begin
                is_load    = 1'b1;
                addr       = i_rd_m + {26'd0, d, 2'b00};
                o_res.size = SZ_LONG;
                o_res.dreg = n;
            end else if (i_instr[15:8] == OP_MOVB) begin
                is_load    = 1'b1;
                addr       = i_rd_m + {28'd0, d};
                o_res.size = SZ_BYTE;
            end else if (i_instr[15:8] == OP_MOVW) begin
                is_load    = 1'b1;
                addr       = i_rd_m + {27'd0, d, 1'b0};
                o_res.size = SZ_WORD;
            end else begin
                o_res.status = ST_UNDEF;
            end

            p2 = addr[31:29] == AREA_P2;
            p4 = addr[31:29] == AREA_P4;
            if (is_load) begin
                o_res.addr = addr[28:0];
                if (p2 || p4) begin
                    o_res.status  = ST_REQUEST;
                    o_res.region  = p4;
                    o_res.cyc     = 2'd2;
                    o_state.pend  = 1'b1;
                    o_state.pdest = o_res.dreg;
                    o_state.psize = o_res.size;
                end else begin
                    o_res.status = ST_UNMAPPED;
                    o_res.dreg   = '0;
                end
            end
        end

        o_wr.addr = o_res.dreg;
        o_wr.data = o_res.dval;
        o_res.t   = o_state.t;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sh4x_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct packed {
        t_action     act;
        logic [15:0] word;
        logic [31:0] data;
    } t_stim_item;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [15:0] instr_word, [47:16] load_data
    logic [47:0]  s_tdata = '0;
    // [0] action
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [31:0] instr_pc, [60:32] mem_address, [62:61] mem_size, [63] mem_region,
    // [67:64] dest_reg, [99:68] dest_value, [100] t_flag, [102:101] instr_cycles
    logic [103:0] m_tdata;
    // [2:0] status
    logic [2:0]   m_tuser;

    sh4_subset_execute_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // architectural shadow of the execute unit
    logic [31:0] arch_regs [16];
    logic        arch_t = 1'b0;
    logic [31:0] arch_pc = PC_RESET;
    logic        arch_pend = 1'b0;
    logic [3:0]  arch_pdest = '0;
    t_size       arch_psize = SZ_BYTE;

    t_stim_item  instr_queue [$];
    t_result     expected_results [$];
    int          item_count = 0;
    logic        failed = 1'b0;
    int unsigned cycle_count = 0;

    int          burst_left = 0;
    int          gap_left = 0;
    int          rdy_mode = 0;
    int          rdy_left = 0;

    initial begin
        for (int i = 0; i < 16; i++) begin
            arch_regs[i] = '0;
        end
    end

    function automatic logic [15:0] enc_movi(input int n, input int imm);
        return {OP_MOVI, n[3:0], imm[7:0]};
    endfunction

    function automatic logic [15:0] enc_shift(input int n, input logic [7:0] fn);
        return {OP_SHIFT, n[3:0], fn};
    endfunction

    function automatic logic [15:0] enc_swap(input int n, input int m);
        return {OP_SWAP, n[3:0], m[3:0], FN_SWAP};
    endfunction

    function automatic logic [15:0] enc_movl(input int n, input int m, input int d);
        return {OP_MOVL, n[3:0], m[3:0], d[3:0]};
    endfunction

    function automatic logic [15:0] enc_movb(input int m, input int d);
        return {OP_MOVB, m[3:0], d[3:0]};
    endfunction

    function automatic logic [15:0] enc_movw(input int m, input int d);
        return {OP_MOVW, m[3:0], d[3:0]};
    endfunction

    function automatic logic [7:0] shift_fn(input int idx);
        logic [7:0] fn;
        case (idx)
            0: fn = SH_LL1;
            1: fn = SH_LR1;
            2: fn = SH_LL2;
            3: fn = SH_LR2;
            4: fn = SH_LL8;
            5: fn = SH_LR8;
            6: fn = SH_LL16;
            default: fn = SH_LR16;
        endcase
        return fn;
    endfunction

    task automatic push_exec(input logic [15:0] word);
        t_stim_item it;
        it.act = ACT_EXEC;
        it.word = word;
        it.data = $urandom();
        instr_queue.push_back(it);
        item_count++;
    endtask

    task automatic push_return(input logic [31:0] data);
        t_stim_item it;
        it.act = ACT_RETURN;
        it.word = 16'($urandom());
        it.data = data;
        instr_queue.push_back(it);
        item_count++;
    endtask

    task automatic push_random_alu();
        case ($urandom_range(0, 2))
            0: push_exec(enc_movi($urandom_range(0, 15), $urandom_range(0, 255)));
            1: push_exec(enc_shift($urandom_range(0, 15), shift_fn($urandom_range(0, 7))));
            default: push_exec(enc_swap($urandom_range(0, 15), $urandom_range(0, 15)));
        endcase
    endtask

    // updates the shadow state for one accepted transfer and returns the result it implies
    function automatic t_result execute_item(input t_action act, input logic [15:0] word,
                                             input logic [31:0] data);
        t_result            r;
        logic [3:0]         rn;
        logic [3:0]         rm;
        logic [3:0]         disp;
        logic [7:0]         lo;
        logic [31:0]        v;
        logic [31:0]        ea;
        logic signed [31:0] sv;
        logic               is_load;
        logic               shift_ok;
        r = '0;
        is_load = 1'b0;
        shift_ok = 1'b1;
        rn = word[11:8];
        rm = word[7:4];
        disp = word[3:0];
        lo = word[7:0];
        ea = '0;
        if (act == ACT_RETURN) begin
            r.pc = arch_pc - PC_STEP;
            if (arch_pend) begin
                case (arch_psize)
                    SZ_BYTE: sv = $signed(data[7:0]);
                    SZ_WORD: sv = $signed(data[15:0]);
                    default: sv = $signed(data);
                endcase
                arch_regs[arch_pdest] = sv;
                r.status = ST_LOADED;
                r.dreg = arch_pdest;
                r.dval = sv;
                r.size = arch_psize;
                arch_pend = 1'b0;
            end
        end else begin
            r.pc = arch_pc;
            arch_pc = arch_pc + PC_STEP;
            if (word[15:12] == OP_MOVI) begin
                sv = $signed(lo);
                arch_regs[rn] = sv;
                r.dreg = rn;
                r.dval = sv;
                r.cyc = 2'd1;
            end else if (word[15:12] == OP_SHIFT) begin
                v = arch_regs[rn];
                case (lo)
                    SH_LL1: begin
                        arch_t = v[31];
                        v = v << 1;
                    end
                    SH_LR1: begin
                        arch_t = v[0];
                        v = v >> 1;
                    end
                    SH_LL2: v = v << 2;
                    SH_LR2: v = v >> 2;
                    SH_LL8: v = v << 8;
                    SH_LR8: v = v >> 8;
                    SH_LL16: v = v << 16;
                    SH_LR16: v = v >> 16;
                    default: shift_ok = 1'b0;
                endcase
                if (shift_ok) begin
                    arch_regs[rn] = v;
                    r.dreg = rn;
                    r.dval = v;
                    r.cyc = 2'd1;
                end else begin
                    r.status = ST_UNDEF;
                end
            end else if (word[15:12] == OP_SWAP && disp == FN_SWAP) begin
                v = arch_regs[rm];
                v = {v[15:0], v[31:16]};
                arch_regs[rn] = v;
                r.dreg = rn;
                r.dval = v;
                r.cyc = 2'd1;
            end else if (word[15:12] == OP_MOVL) begin
                is_load = 1'b1;
                ea = arch_regs[rm] + {26'd0, disp, 2'b00};
                r.size = SZ_LONG;
                r.dreg = rn;
            end else if (word[15:8] == OP_MOVB) begin
                is_load = 1'b1;
                ea = arch_regs[rm] + {28'd0, disp};
                r.size = SZ_BYTE;
            end else if (word[15:8] == OP_MOVW) begin
                is_load = 1'b1;
                ea = arch_regs[rm] + {27'd0, disp, 1'b0};
                r.size = SZ_WORD;
            end else begin
                r.status = ST_UNDEF;
            end
            if (is_load) begin
                r.addr = ea[28:0];
                if (ea[31:29] == AREA_P2 || ea[31:29] == AREA_P4) begin
                    r.status = ST_REQUEST;
                    r.region = (ea[31:29] == AREA_P4);
                    r.cyc = 2'd2;
                    arch_pend = 1'b1;
                    arch_pdest = r.dreg;
                    arch_psize = r.size;
                end else begin
                    r.status = ST_UNMAPPED;
                    r.dreg = '0;
                end
            end
        end
        r.t = arch_t;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
            failed = 1'b1;
        end
    endtask

    // driver: bursts of transfers separated by random gaps
    always @(posedge clk) begin
        t_stim_item it;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(execute_item(t_action'(s_tuser[0]), s_tdata[15:0],
                                                        s_tdata[47:16]));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || instr_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end else begin
                    it = instr_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {it.data, it.word};
                    s_tuser <= it.act;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // monitor: checks each result transfer, stalls in modes of random length
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got status %0d pc %h",
                             $time, m_tuser, m_tdata[31:0]);
                    failed = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", {29'd0, want.status}, {29'd0, m_tuser});
                    check_field("instr_pc", want.pc, m_tdata[31:0]);
                    check_field("mem_address", {3'd0, want.addr}, {3'd0, m_tdata[60:32]});
                    check_field("mem_size", {30'd0, want.size}, {30'd0, m_tdata[62:61]});
                    check_field("mem_region", {31'd0, want.region}, {31'd0, m_tdata[63]});
                    check_field("dest_reg", {28'd0, want.dreg}, {28'd0, m_tdata[67:64]});
                    check_field("dest_value", want.dval, m_tdata[99:68]);
                    check_field("t_flag", {31'd0, want.t}, {31'd0, m_tdata[100]});
                    check_field("instr_cycles", {30'd0, want.cyc}, {30'd0, m_tdata[102:101]});
                    check_field("pad", 32'd0, {31'd0, m_tdata[103]});
                end
            end
            if (rdy_left == 0) begin
                rdy_mode = $urandom_range(0, 2);
                rdy_left = $urandom_range(10, 150);
            end else begin
                rdy_left--;
            end
            case (rdy_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL sh4_subset_execute_unit");
            $finish;
        end
    end

    initial begin
        int base;
        int imm;
        int nl;
        int nr;
        int pick;

        // directed: return with nothing pending, immediates at the extremes
        push_return($urandom());
        push_exec(enc_movi(1, 8'h7F));
        push_exec(enc_movi(2, 8'h80));
        push_exec(enc_movi(15, 8'hFF));
        push_exec(enc_movi(0, 8'h00));
        // every shift form, 1-bit forms moving a one into t
        push_exec(enc_shift(2, SH_LL1));
        push_exec(enc_shift(1, SH_LR1));
        push_exec(enc_shift(15, SH_LL2));
        push_exec(enc_shift(15, SH_LR2));
        push_exec(enc_shift(2, SH_LL8));
        push_exec(enc_shift(2, SH_LR8));
        push_exec(enc_shift(1, SH_LL16));
        push_exec(enc_shift(15, SH_LR16));
        push_exec(enc_swap(3, 2));
        push_exec(16'hFFFF);
        // long load from a low address is unmapped
        push_exec(enc_movl(4, 0, 1));
        // build 0xa0000000 in r5, then a p2 load
        push_exec(enc_movi(5, 8'hA0));
        push_exec(enc_shift(5, SH_LL16));
        push_exec(enc_shift(5, SH_LL8));
        push_exec(enc_movl(6, 5, 15));
        // execute while pending, then a p4 byte load replaces the pending one
        push_exec(enc_movi(7, 8'h01));
        push_exec(enc_movb(3, 15));
        push_return(32'h0000_0080);
        push_exec(enc_movw(0, 15));
        push_return(32'h1234_8000);

        while (item_count < 25 + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // load sequence: set up a base, issue loads, return the data
                base = $urandom_range(0, 15);
                case ($urandom_range(0, 3))
                    0: imm = $urandom_range(8'hA0, 8'hBF);
                    1: imm = $urandom_range(8'hE0, 8'hFF);
                    2: imm = $urandom_range(0, 255);
                    default: imm = $urandom_range(8'hA0, 8'hBF);
                endcase
                push_exec(enc_movi(base, imm));
                if ($urandom_range(0, 9) < 7) begin
                    push_exec(enc_shift(base, SH_LL16));
                    push_exec(enc_shift(base, SH_LL8));
                end
                nl = $urandom_range(1, 3);
                for (int i = 0; i < nl; i++) begin
                    case ($urandom_range(0, 2))
                        0: push_exec(enc_movl($urandom_range(0, 15), base,
                                              $urandom_range(0, 15)));
                        1: push_exec(enc_movb(base, $urandom_range(0, 15)));
                        default: push_exec(enc_movw(base, $urandom_range(0, 15)));
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        push_random_alu();
                    end
                end
                pick = $urandom_range(0, 9);
                nr = (pick == 0) ? 0 : ((pick == 1) ? 2 : 1);
                for (int i = 0; i < nr; i++) begin
                    push_return($urandom());
                end
            end else if (pick < 82) begin
                push_random_alu();
            end else if (pick < 94) begin
                push_exec(16'($urandom()));
            end else begin
                push_return($urandom());
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (instr_queue.size() != 0 || s_tvalid) begin
            @(posedge clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (!failed) begin
            $display("PASS sh4_subset_execute_unit");
        end else begin
            $display("FAIL sh4_subset_execute_unit");
        end
        $finish;
    end

endmodule
